/* hdl/sftt_pkg.sv */
// Shared types and constants for the sparse matrix fast transpose block.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package sftt_pkg;

    localparam int MAX_TERMS  = 64;
    localparam int MAX_COLS   = 64;
    localparam int ROW_BITS   = 8;
    localparam int COL_BITS   = 6;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_W     = $clog2(MAX_TERMS);
    localparam int CADDR_W    = $clog2(MAX_COLS);
    localparam int CNT_W      = $clog2(MAX_TERMS + 1);
    localparam int NCOLS_W    = 7;
    localparam int DROP_W     = 8;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;
    localparam int PC_W       = 5;
    localparam int OP_W       = 4;
    localparam int COND_W     = 3;

    // Datapath operations, one per microcode step
    localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd1;
    localparam logic [OP_W-1:0] OP_INIT       = 4'd2;
    localparam logic [OP_W-1:0] OP_LOAD       = 4'd3;
    localparam logic [OP_W-1:0] OP_RD_SRC     = 4'd4;
    localparam logic [OP_W-1:0] OP_RD_CM_SRC  = 4'd5;
    localparam logic [OP_W-1:0] OP_CM_INC     = 4'd6;
    localparam logic [OP_W-1:0] OP_PFX_INIT   = 4'd7;
    localparam logic [OP_W-1:0] OP_RD_CM_I    = 4'd8;
    localparam logic [OP_W-1:0] OP_PFX_WR     = 4'd9;
    localparam logic [OP_W-1:0] OP_SCATTER    = 4'd10;
    localparam logic [OP_W-1:0] OP_RD_TRN     = 4'd11;
    localparam logic [OP_W-1:0] OP_EMIT       = 4'd12;
    localparam logic [OP_W-1:0] OP_EMIT_EMPTY = 4'd13;

    // Jump conditions
    localparam logic [COND_W-1:0] C_NEXT      = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS    = 3'd1;
    localparam logic [COND_W-1:0] C_COL_MORE  = 3'd2;
    localparam logic [COND_W-1:0] C_TERM_MORE = 3'd3;
    localparam logic [COND_W-1:0] C_NO_LAST   = 3'd4;
    localparam logic [COND_W-1:0] C_EMPTY     = 3'd5;
    localparam logic [COND_W-1:0] C_OUT_BUSY  = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              i_inc;
        logic              i_clr;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } uword_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            i_inc;
        logic            i_clr;
    } dp_ctrl_t;

    typedef struct packed {
        logic col_more;
        logic term_more;
        logic in_last;
        logic empty;
        logic out_busy;
    } dp_flags_t;

    // Source term as it arrives, row in the low bits
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [COL_BITS-1:0]   col;
        logic [ROW_BITS-1:0]   row;
    } src_term_t;

    // Transposed term, laid out as on the output data bus
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [ROW_BITS-1:0]   out_col;
        logic [COL_BITS-1:0]   out_row;
    } trn_term_t;

endpackage

/* hdl/sparse_triple_fast_transpose_top.sv */
// Top level of the sparse matrix fast transpose block (coordinate-form terms).
// Instantiates sftt_seq and sftt_datapath; depends on sftt_pkg.
//
// Load the nonzero terms of a sparse matrix, one request per cycle, on the
// input stream; tlast marks the final term and starts the counting-sort
// transpose. Terms are taken only while s_tready is high. A term whose column
// is at or beyond num_cols, or that arrives with 64 terms already held, is
// dropped and counted (saturating at 255). After the final term the input
// stalls while a microcoded sequencer walks the stores: a pass over the stored
// terms counts columns, a pass over the 64 columns forms the running start
// positions, a pass over the terms scatters them, a pass over the terms emits
// them, then a pass zeros the column memory. The count and scatter loops take
// a registered source read, a registered column read and a column write per
// term; the emit loop takes a registered read, a check that the output
// register is free, and the load, and waits while the output stalls. Results
// leave in source-column order, rows and columns swapped, with out_valid in
// tuser and out_last in tlast; an empty set gives one result with out_valid 0.
// After reset the same clearing pass runs before the first input is taken;
// configuration writes are taken at any time but belong only in idle periods.
module sparse_triple_fast_transpose_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sftt_pkg::NCOLS_W-1:0]        cfg_wr_data,  // num_cols
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // term_row[7:0], term_col[13:8], term_value[45:14], zero pad [47:46]
    input  logic [sftt_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,      // last_term
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_row[5:0], out_col[13:6], out_value[45:14], dropped_terms[53:46],
    // zero pad [55:54]
    output logic [sftt_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser,      // out_valid
    output logic                                m_tlast       // out_last
);
    import sftt_pkg::*;

    dp_ctrl_t  ctrl;
    dp_flags_t flags;

    // Step counter and control store
    sftt_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // Stores, counters and the output register
    sftt_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .flags       (flags),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // The final input request must close the load window at once
    a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still taken after the final term");

    // An empty-set marker is always the final result
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("empty-set result without last mark");

    // The emit step must never overwrite a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ((ctrl.op == OP_EMIT) || (ctrl.op == OP_EMIT_EMPTY)) |-> !m_tvalid)
        else $error("output register loaded while occupied");

endmodule

/* hdl/sftt_seq.sv */
// Microcode sequencer: step counter, control store and jump logic.
// Depends on sftt_pkg.
module sftt_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  sftt_pkg::dp_flags_t flags,
    output sftt_pkg::dp_ctrl_t  ctrl
);
    import sftt_pkg::*;

    localparam logic [PC_W-1:0] S_CLR     = 5'd0;
    localparam logic [PC_W-1:0] S_INIT    = 5'd1;
    localparam logic [PC_W-1:0] S_LOAD    = 5'd2;
    localparam logic [PC_W-1:0] S_CHK     = 5'd3;
    localparam logic [PC_W-1:0] S_CNT_A   = 5'd4;
    localparam logic [PC_W-1:0] S_CNT_B   = 5'd5;
    localparam logic [PC_W-1:0] S_CNT_C   = 5'd6;
    localparam logic [PC_W-1:0] S_PFX_0   = 5'd7;
    localparam logic [PC_W-1:0] S_PFX_A   = 5'd8;
    localparam logic [PC_W-1:0] S_PFX_B   = 5'd9;
    localparam logic [PC_W-1:0] S_SCT_0   = 5'd10;
    localparam logic [PC_W-1:0] S_SCT_A   = 5'd11;
    localparam logic [PC_W-1:0] S_SCT_B   = 5'd12;
    localparam logic [PC_W-1:0] S_SCT_C   = 5'd13;
    localparam logic [PC_W-1:0] S_EMT_0   = 5'd14;
    localparam logic [PC_W-1:0] S_EMT_A   = 5'd15;
    localparam logic [PC_W-1:0] S_EMT_B   = 5'd16;
    localparam logic [PC_W-1:0] S_EMT_C   = 5'd17;
    localparam logic [PC_W-1:0] S_DONE    = 5'd18;
    localparam logic [PC_W-1:0] S_EMP_A   = 5'd19;
    localparam logic [PC_W-1:0] S_EMP_B   = 5'd20;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          uw;
    logic            take;

    function automatic uword_t mk(
        input logic [OP_W-1:0]   op,
        input logic              inc,
        input logic              clr,
        input logic [COND_W-1:0] cond,
        input logic [PC_W-1:0]   target
    );
        uword_t w;
        w.op     = op;
        w.i_inc  = inc;
        w.i_clr  = clr;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control store
    always_comb
    begin
        case (pc_reg)
            S_CLR:   uw = mk(OP_CLEAR,      1'b1, 1'b0, C_COL_MORE,  S_CLR);
            S_INIT:  uw = mk(OP_INIT,       1'b0, 1'b1, C_NEXT,      S_INIT);
            S_LOAD:  uw = mk(OP_LOAD,       1'b0, 1'b0, C_NO_LAST,   S_LOAD);
            S_CHK:   uw = mk(OP_NOP,        1'b0, 1'b0, C_EMPTY,     S_EMP_A);
            S_CNT_A: uw = mk(OP_RD_SRC,     1'b0, 1'b0, C_NEXT,      S_CNT_A);
            S_CNT_B: uw = mk(OP_RD_CM_SRC,  1'b0, 1'b0, C_NEXT,      S_CNT_B);
            S_CNT_C: uw = mk(OP_CM_INC,     1'b1, 1'b0, C_TERM_MORE, S_CNT_A);
            S_PFX_0: uw = mk(OP_PFX_INIT,   1'b0, 1'b1, C_NEXT,      S_PFX_0);
            S_PFX_A: uw = mk(OP_RD_CM_I,    1'b0, 1'b0, C_NEXT,      S_PFX_A);
            S_PFX_B: uw = mk(OP_PFX_WR,     1'b1, 1'b0, C_COL_MORE,  S_PFX_A);
            S_SCT_0: uw = mk(OP_NOP,        1'b0, 1'b1, C_NEXT,      S_SCT_0);
            S_SCT_A: uw = mk(OP_RD_SRC,     1'b0, 1'b0, C_NEXT,      S_SCT_A);
            S_SCT_B: uw = mk(OP_RD_CM_SRC,  1'b0, 1'b0, C_NEXT,      S_SCT_B);
            S_SCT_C: uw = mk(OP_SCATTER,    1'b1, 1'b0, C_TERM_MORE, S_SCT_A);
            S_EMT_0: uw = mk(OP_NOP,        1'b0, 1'b1, C_NEXT,      S_EMT_0);
            S_EMT_A: uw = mk(OP_RD_TRN,     1'b0, 1'b0, C_NEXT,      S_EMT_A);
            S_EMT_B: uw = mk(OP_NOP,        1'b0, 1'b0, C_OUT_BUSY,  S_EMT_B);
            S_EMT_C: uw = mk(OP_EMIT,       1'b1, 1'b0, C_TERM_MORE, S_EMT_A);
            S_DONE:  uw = mk(OP_NOP,        1'b0, 1'b1, C_ALWAYS,    S_CLR);
            S_EMP_A: uw = mk(OP_NOP,        1'b0, 1'b0, C_OUT_BUSY,  S_EMP_A);
            S_EMP_B: uw = mk(OP_EMIT_EMPTY, 1'b0, 1'b0, C_ALWAYS,    S_DONE);
            default: uw = mk(OP_NOP,        1'b0, 1'b1, C_ALWAYS,    S_CLR);
        endcase
    end

    always_comb
    begin
        case (uw.cond)
            C_NEXT:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_COL_MORE:  take = flags.col_more;
            C_TERM_MORE: take = flags.term_more;
            C_NO_LAST:   take = !flags.in_last;
            C_EMPTY:     take = flags.empty;
            C_OUT_BUSY:  take = flags.out_busy;
            default:     take = 1'b1;
        endcase
    end

    assign pc_next = take ? uw.target : pc_reg + 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_CLR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.op    = uw.op;
    assign ctrl.i_inc = uw.i_inc;
    assign ctrl.i_clr = uw.i_clr;

endmodule

/* hdl/sftt_datapath.sv */
// Datapath: term stores, column count/start memory, loop counter, output register.
// Driven by the control word from sftt_seq; depends on sftt_pkg.
module sftt_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sftt_pkg::dp_ctrl_t                  ctrl,
    output sftt_pkg::dp_flags_t                 flags,
    input  logic                                cfg_wr_en,
    input  logic [sftt_pkg::NCOLS_W-1:0]        cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sftt_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sftt_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import sftt_pkg::*;

    src_term_t              src_mem [MAX_TERMS];
    trn_term_t              trn_mem [MAX_TERMS];
    logic [CNT_W-1:0]       cm_mem  [MAX_COLS];

    logic [NCOLS_W-1:0]     num_cols_reg;
    logic [CNT_W-1:0]       stored_reg, stored_next;
    logic [DROP_W-1:0]      drop_reg, drop_next;
    logic [CNT_W-1:0]       i_reg, i_next;
    logic [CNT_W-1:0]       sum_reg, sum_next;
    src_term_t              src_rd_reg;
    trn_term_t              trn_rd_reg;
    logic [CNT_W-1:0]       cm_rd_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]  m_data_reg;
    logic                   m_user_reg;
    logic                   m_last_reg;

    src_term_t              in_term;
    logic                   acc;
    logic                   bad_col;
    logic                   full;
    logic                   cm_we;
    logic [CADDR_W-1:0]     cm_waddr;
    logic [CNT_W-1:0]       cm_wdata;
    logic                   cm_re;
    logic [CADDR_W-1:0]     cm_raddr;
    logic                   load_out;

    assign in_term  = src_term_t'(s_tdata[$bits(src_term_t)-1:0]);
    assign s_tready = (ctrl.op == OP_LOAD);
    assign acc      = s_tvalid && s_tready;
    assign bad_col  = ({1'b0, in_term.col} >= num_cols_reg);
    assign full     = (stored_reg >= CNT_W'(MAX_TERMS));

    assign flags.col_more  = (i_reg < CNT_W'(MAX_COLS - 1));
    assign flags.term_more = ((i_reg + CNT_W'(1)) < stored_reg);
    assign flags.in_last   = acc && s_tlast;
    assign flags.empty     = (stored_reg == '0);
    assign flags.out_busy  = m_valid_reg && !m_tready;

    // Column memory port selection
    always_comb
    begin
        cm_we    = 1'b0;
        cm_waddr = i_reg[CADDR_W-1:0];
        cm_wdata = '0;
        cm_re    = 1'b0;
        cm_raddr = i_reg[CADDR_W-1:0];
        case (ctrl.op)
            OP_CLEAR:
            begin
                cm_we = 1'b1;
            end
            OP_RD_CM_SRC:
            begin
                cm_re    = 1'b1;
                cm_raddr = src_rd_reg.col;
            end
            OP_RD_CM_I:
            begin
                cm_re = 1'b1;
            end
            OP_CM_INC, OP_SCATTER:
            begin
                cm_we    = 1'b1;
                cm_waddr = src_rd_reg.col;
                cm_wdata = cm_rd_reg + CNT_W'(1);
            end
            OP_PFX_WR:
            begin
                cm_we    = 1'b1;
                cm_wdata = sum_reg;
            end
            default:
            begin
                cm_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cm_we)
        begin
            cm_mem[cm_waddr] <= cm_wdata;
        end
        if (cm_re)
        begin
            cm_rd_reg <= cm_mem[cm_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && !bad_col && !full)
        begin
            src_mem[stored_reg[ADDR_W-1:0]] <= in_term;
        end
        if (ctrl.op == OP_RD_SRC)
        begin
            src_rd_reg <= src_mem[i_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_SCATTER)
        begin
            trn_mem[cm_rd_reg[ADDR_W-1:0]] <= '{value:   src_rd_reg.value,
                                                out_col: src_rd_reg.row,
                                                out_row: src_rd_reg.col};
        end
        if (ctrl.op == OP_RD_TRN)
        begin
            trn_rd_reg <= trn_mem[i_reg[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        stored_next = stored_reg;
        drop_next   = drop_reg;
        if (ctrl.op == OP_INIT)
        begin
            stored_next = '0;
            drop_next   = '0;
        end
        else if (acc)
        begin
            if (bad_col || full)
            begin
                if (drop_reg != '1)
                begin
                    drop_next = drop_reg + DROP_W'(1);
                end
            end
            else
            begin
                stored_next = stored_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        i_next = i_reg;
        if (ctrl.i_clr)
        begin
            i_next = '0;
        end
        else if (ctrl.i_inc)
        begin
            i_next = i_reg + CNT_W'(1);
        end
        sum_next = sum_reg;
        if (ctrl.op == OP_PFX_INIT)
        begin
            sum_next = '0;
        end
        else if (ctrl.op == OP_PFX_WR)
        begin
            sum_next = sum_reg + cm_rd_reg;
        end
    end

    assign load_out = (ctrl.op == OP_EMIT) || (ctrl.op == OP_EMIT_EMPTY);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_EMIT)
        begin
            m_data_reg <= {{(OUT_DATA_W - DROP_W - $bits(trn_term_t)){1'b0}},
                           drop_reg, trn_rd_reg};
            m_user_reg <= 1'b1;
            m_last_reg <= !flags.term_more;
        end
        else if (ctrl.op == OP_EMIT_EMPTY)
        begin
            m_data_reg <= {{(OUT_DATA_W - DROP_W - $bits(trn_term_t)){1'b0}},
                           drop_reg, {$bits(trn_term_t){1'b0}}};
            m_user_reg <= 1'b0;
            m_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= NCOLS_W'(MAX_COLS);
            stored_reg   <= '0;
            drop_reg     <= '0;
            i_reg        <= '0;
            sum_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                num_cols_reg <= cfg_wr_data;
            end
            stored_reg  <= stored_next;
            drop_reg    <= drop_next;
            i_reg       <= i_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule
